// ===== rtl/core/ptd_pkg.sv =====
// ----------------------------------------------------------------------------
// ptd_pkg
// Shared types and constants of the periodic task dispatcher: operation
// codes, controller states, command and status bundles.
// ----------------------------------------------------------------------------
`default_nettype none

package ptd_pkg;

  // Payload field widths
  localparam int OP_W     = 2;
  localparam int GROUP_W  = 3;
  localparam int SLOT_W   = 5;
  localparam int TIME_W   = 32;
  localparam int CFG_W    = 4;
  localparam int CFG_IDX_W = 1;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_GROUPS_IN_USE     = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BACKGROUND_GROUPS = 1'd1;

  // Configuration reset values
  localparam logic [CFG_W-1:0] GROUPS_IN_USE_RST     = 4'd8;
  localparam logic [CFG_W-1:0] BACKGROUND_GROUPS_RST = 4'd1;

  typedef enum logic [OP_W-1:0] {
    OP_TICK     = 2'd0,
    OP_DISPATCH = 2'd1,
    OP_REGISTER = 2'd2,
    OP_REMOVE   = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_SCAN,
    ST_DRAIN,
    ST_PICK,
    ST_APPLY,
    ST_WRITE,
    ST_EMIT
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic latch;      // capture request, clear pick result
    logic scan_step;  // read task entry at scan position, advance
    logic pick;       // select task, reload background when idle
    logic apply;      // clear picked task bits
    logic write_op;   // register or remove a task
    logic emit;       // load result register
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    op_t  op;
    logic scan_none;
    logic scan_last;
    logic out_free;
  } stat_t;

endpackage

`default_nettype wire

// ===== rtl/core/ptd_req_if.sv =====
// ----------------------------------------------------------------------------
// ptd_req_if
// Request channel of the dispatcher: valid/ready with the request fields.
// ----------------------------------------------------------------------------
`default_nettype none

interface ptd_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  op;
  logic [2:0]  group;
  logic [4:0]  slot;
  logic [31:0] period;
  logic [31:0] first_start;

  modport source (output valid, op, group, slot, period, first_start, input ready);
  modport sink   (input valid, op, group, slot, period, first_start, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/ptd_rsp_if.sv =====
// ----------------------------------------------------------------------------
// ptd_rsp_if
// Result channel of the dispatcher: valid/ready with the result fields.
// ----------------------------------------------------------------------------
`default_nettype none

interface ptd_rsp_if;
  logic        valid;
  logic        ready;
  logic        dispatched;
  logic [2:0]  picked_group;
  logic [4:0]  picked_slot;
  logic        from_background;
  logic [31:0] now_tick;

  modport source (output valid, dispatched, picked_group, picked_slot,
                  from_background, now_tick, input ready);
  modport sink   (input valid, dispatched, picked_group, picked_slot,
                  from_background, now_tick, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/periodic_task_dispatcher_top.sv =====
// ----------------------------------------------------------------------------
// periodic_task_dispatcher_top
// Task scheduler over groups of task slots: tick, dispatch, register, remove.
// ----------------------------------------------------------------------------
// Usage:
//   req carries one request (op, group, slot, period, first_start) per
//   valid/ready handshake; rsp returns exactly one result per request.
//   The block serves one request at a time; req.ready is high while idle.
//   Steps from acceptance to rsp.valid:
//     tick:              decode, a scan that reads the start and period
//                        entries of every slot of the scanned groups, one slot
//                        per cycle, then drain and emit; decode and emit alone
//                        when no group is scanned
//     dispatch:          decode, pick with period table read, apply, emit
//     register / remove: decode, table write, emit
//   A new request may be accepted in the first cycle that rsp.valid is high,
//   while the result still waits in the output register.
//   Reset clears tick counter and all task masks and restores the group
//   registers (8 scanned, 1 background); no clearing pass is needed.
//   If rsp.ready stays low, a finished result holds and the next request
//   waits before its result is loaded.
//   Configuration is written through cfg_we/cfg_index/cfg_data while idle.
// ----------------------------------------------------------------------------
`default_nettype none

module periodic_task_dispatcher_top #(
  parameter int GROUP_COUNT     = 8,
  parameter int SLOTS_PER_GROUP = 32
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_we,
  input  wire logic [ptd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [ptd_pkg::CFG_W-1:0]     cfg_data,
  ptd_req_if.sink                            req,
  ptd_rsp_if.source                          rsp
);

  ptd_pkg::cmd_t  cmd;
  ptd_pkg::stat_t stat;

  ptd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (req.valid),
    .in_ready (req.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  ptd_datapath #(
    .GROUP_COUNT     (GROUP_COUNT),
    .SLOTS_PER_GROUP (SLOTS_PER_GROUP)
  ) u_datapath (
    .clk                 (clk),
    .rst                 (rst),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data),
    .in_op               (req.op),
    .in_group            (req.group),
    .in_slot             (req.slot),
    .in_period           (req.period),
    .in_first_start      (req.first_start),
    .cmd                 (cmd),
    .stat                (stat),
    .out_valid           (rsp.valid),
    .out_ready           (rsp.ready),
    .out_dispatched      (rsp.dispatched),
    .out_picked_group    (rsp.picked_group),
    .out_picked_slot     (rsp.picked_slot),
    .out_from_background (rsp.from_background),
    .out_now_tick        (rsp.now_tick)
  );

  // One request in flight at a time
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    (req.valid && req.ready) |=> !req.ready)
    else $error("request accepted while another is in flight");

  // Background flag only with a picked task
  a_bg_needs_pick: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.from_background) |-> rsp.dispatched)
    else $error("background flag without dispatch");

  // Idle or non-dispatch results report no task
  a_idle_zero: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && !rsp.dispatched) |-> (rsp.picked_group == '0 && rsp.picked_slot == '0))
    else $error("task reported without dispatch");

endmodule

`default_nettype wire

// ===== rtl/core/ptd_ram.sv =====
// ----------------------------------------------------------------------------
// ptd_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module ptd_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  wire logic                                   clk,
  input  wire logic                                   we,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                       wdata,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                            rdata
);

  logic [WIDTH-1:0] mem [0:DEPTH-1];

  // Write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== rtl/core/ptd_ctrl.sv =====
// ----------------------------------------------------------------------------
// ptd_ctrl
// Controller of the dispatcher: sequences each request through decode, task
// scan, pick or table write, then hands the result to the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module ptd_ctrl (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire ptd_pkg::stat_t stat,
  output ptd_pkg::cmd_t      cmd
);

  ptd_pkg::state_t state;
  ptd_pkg::state_t state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ptd_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      ptd_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.latch  = 1'b1;
          state_next = ptd_pkg::ST_DECODE;
        end
      end
      ptd_pkg::ST_DECODE: begin
        case (stat.op)
          ptd_pkg::OP_TICK: begin
            state_next = stat.scan_none ? ptd_pkg::ST_EMIT : ptd_pkg::ST_SCAN;
          end
          ptd_pkg::OP_DISPATCH: state_next = ptd_pkg::ST_PICK;
          default:              state_next = ptd_pkg::ST_WRITE;
        endcase
      end
      ptd_pkg::ST_SCAN: begin
        cmd.scan_step = 1'b1;
        if (stat.scan_last) begin
          state_next = ptd_pkg::ST_DRAIN;
        end
      end
      ptd_pkg::ST_DRAIN: state_next = ptd_pkg::ST_EMIT;
      ptd_pkg::ST_PICK: begin
        cmd.pick   = 1'b1;
        state_next = ptd_pkg::ST_APPLY;
      end
      ptd_pkg::ST_APPLY: begin
        cmd.apply  = 1'b1;
        state_next = ptd_pkg::ST_EMIT;
      end
      ptd_pkg::ST_WRITE: begin
        cmd.write_op = 1'b1;
        state_next   = ptd_pkg::ST_EMIT;
      end
      ptd_pkg::ST_EMIT: begin
        if (stat.out_free) begin
          cmd.emit   = 1'b1;
          state_next = ptd_pkg::ST_IDLE;
        end
      end
      default: state_next = ptd_pkg::ST_IDLE;
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/core/ptd_datapath.sv =====
// ----------------------------------------------------------------------------
// ptd_datapath
// Datapath of the dispatcher: tick counter, registered and active masks,
// start and period tables in RAM, scan pipeline, picker and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module ptd_datapath #(
  parameter int GROUP_COUNT     = 8,
  parameter int SLOTS_PER_GROUP = 32
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              cfg_we,
  input  wire logic [ptd_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [ptd_pkg::CFG_W-1:0]         cfg_data,
  input  wire logic [ptd_pkg::OP_W-1:0]          in_op,
  input  wire logic [ptd_pkg::GROUP_W-1:0]       in_group,
  input  wire logic [ptd_pkg::SLOT_W-1:0]        in_slot,
  input  wire logic [ptd_pkg::TIME_W-1:0]        in_period,
  input  wire logic [ptd_pkg::TIME_W-1:0]        in_first_start,
  input  wire ptd_pkg::cmd_t                     cmd,
  output ptd_pkg::stat_t                         stat,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output logic                                   out_dispatched,
  output logic [ptd_pkg::GROUP_W-1:0]            out_picked_group,
  output logic [ptd_pkg::SLOT_W-1:0]             out_picked_slot,
  output logic                                   out_from_background,
  output logic [ptd_pkg::TIME_W-1:0]             out_now_tick
);

  localparam int DEPTH = GROUP_COUNT * SLOTS_PER_GROUP;
  localparam int AW    = DEPTH > 1 ? $clog2(DEPTH) : 1;
  localparam int GIW   = GROUP_COUNT > 1 ? $clog2(GROUP_COUNT) : 1;
  localparam int SIW   = SLOTS_PER_GROUP > 1 ? $clog2(SLOTS_PER_GROUP) : 1;
  localparam int TW    = ptd_pkg::TIME_W;

  function automatic logic [AW-1:0] task_addr(input logic [GIW-1:0] g,
                                               input logic [SIW-1:0] s);
    return AW'(int'(g) * SLOTS_PER_GROUP + int'(s));
  endfunction

  // Configuration and state
  logic [ptd_pkg::CFG_W-1:0] groups_in_use;
  logic [ptd_pkg::CFG_W-1:0] background_groups;
  logic [TW-1:0]             tick_count;
  logic [SLOTS_PER_GROUP-1:0] reg_mask [GROUP_COUNT];
  logic [SLOTS_PER_GROUP-1:0] act_mask [GROUP_COUNT];

  // Captured request
  ptd_pkg::op_t               op_q;
  logic [ptd_pkg::GROUP_W-1:0] group_q;
  logic [ptd_pkg::SLOT_W-1:0]  slot_q;
  logic [TW-1:0]               period_q;
  logic [TW-1:0]               first_q;

  // Scan pipeline
  logic [GIW-1:0] scan_g;
  logic [SIW-1:0] scan_s;
  logic           proc_valid;
  logic [GIW-1:0] proc_g;
  logic [SIW-1:0] proc_s;

  // Pick result
  logic           pick_hit;
  logic [GIW-1:0] pick_g;
  logic [SIW-1:0] pick_s;
  logic           pick_bg;

  // RAM ports
  logic [TW-1:0]  start_rdata;
  logic [TW-1:0]  period_rdata;
  logic           start_we;
  logic [AW-1:0]  start_waddr;
  logic [TW-1:0]  start_wdata;
  logic           period_we;
  logic [AW-1:0]  op_addr;
  logic [AW-1:0]  scan_addr;
  logic [AW-1:0]  period_raddr;

  // Derived group limits
  logic [4:0] scan_groups;
  logic [4:0] bg_groups;
  logic [4:0] first_bg;
  logic       op_in_range;
  logic [GIW-1:0] op_g;
  logic [SIW-1:0] op_s;

  // Combinational pick
  logic           sel_hit;
  logic [GIW-1:0] sel_g;
  logic [SIW-1:0] sel_s;
  logic [SLOTS_PER_GROUP-1:0] sel_mask;

  // Tick test
  logic [TW-1:0] elapsed;
  logic          proc_fire;

  // Clamp group counts
  always_comb begin
    scan_groups = ({1'b0, groups_in_use} > 5'(GROUP_COUNT)) ? 5'(GROUP_COUNT)
                                                            : {1'b0, groups_in_use};
    bg_groups   = ({1'b0, background_groups} > scan_groups) ? scan_groups
                                                            : {1'b0, background_groups};
    first_bg    = scan_groups - bg_groups;
  end

  assign op_in_range = (5'(group_q) < 5'(GROUP_COUNT)) &&
                       (6'(slot_q) < 6'(SLOTS_PER_GROUP));
  assign op_g      = GIW'(group_q);
  assign op_s      = SIW'(slot_q);
  assign op_addr   = task_addr(op_g, op_s);
  assign scan_addr = task_addr(scan_g, scan_s);

  // Pick lowest active slot of lowest active group
  always_comb begin
    sel_hit = 1'b0;
    sel_g   = '0;
    sel_s   = '0;
    for (int g = GROUP_COUNT - 1; g >= 0; g--) begin
      if (5'(g) < scan_groups && |act_mask[g]) begin
        sel_hit = 1'b1;
        sel_g   = GIW'(g);
      end
    end
    sel_mask = act_mask[sel_g];
    for (int s = SLOTS_PER_GROUP - 1; s >= 0; s--) begin
      if (sel_mask[s]) begin
        sel_s = SIW'(s);
      end
    end
  end

  // Due test on the entry read in the previous cycle
  assign elapsed   = tick_count - start_rdata;
  assign proc_fire = proc_valid && reg_mask[proc_g][proc_s] && (elapsed >= period_rdata);

  // RAM write and read selection
  always_comb begin
    start_we     = 1'b0;
    start_waddr  = op_addr;
    start_wdata  = first_q;
    period_we    = 1'b0;
    if (proc_fire) begin
      start_we    = 1'b1;
      start_waddr = task_addr(proc_g, proc_s);
      start_wdata = start_rdata + period_rdata;
    end else if (cmd.write_op && op_q == ptd_pkg::OP_REGISTER && op_in_range) begin
      start_we  = 1'b1;
      period_we = 1'b1;
    end
    period_raddr = cmd.pick ? task_addr(sel_g, sel_s) : scan_addr;
  end

  ptd_ram #(.WIDTH(TW), .DEPTH(DEPTH)) u_start_ram (
    .clk   (clk),
    .we    (start_we),
    .waddr (start_waddr),
    .wdata (start_wdata),
    .raddr (scan_addr),
    .rdata (start_rdata)
  );

  ptd_ram #(.WIDTH(TW), .DEPTH(DEPTH)) u_period_ram (
    .clk   (clk),
    .we    (period_we),
    .waddr (op_addr),
    .wdata (period_q),
    .raddr (period_raddr),
    .rdata (period_rdata)
  );

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      groups_in_use     <= ptd_pkg::GROUPS_IN_USE_RST;
      background_groups <= ptd_pkg::BACKGROUND_GROUPS_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        ptd_pkg::CFG_GROUPS_IN_USE:     groups_in_use     <= cfg_data;
        ptd_pkg::CFG_BACKGROUND_GROUPS: background_groups <= cfg_data;
        default: ;
      endcase
    end
  end

  // Capture request
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      op_q     <= ptd_pkg::op_t'(in_op);
      group_q  <= in_group;
      slot_q   <= in_slot;
      period_q <= in_period;
      first_q  <= in_first_start;
    end
  end

  // Tick counter
  always_ff @(posedge clk) begin
    if (rst) begin
      tick_count <= '0;
    end else if (cmd.latch && ptd_pkg::op_t'(in_op) == ptd_pkg::OP_TICK) begin
      tick_count <= tick_count + 1'b1;
    end
  end

  // Scan position and pipeline stage
  always_ff @(posedge clk) begin
    if (rst) begin
      scan_g     <= '0;
      scan_s     <= '0;
      proc_valid <= 1'b0;
    end else begin
      proc_valid <= cmd.scan_step;
      if (cmd.latch) begin
        scan_g <= '0;
        scan_s <= '0;
      end else if (cmd.scan_step) begin
        if (32'(scan_s) == 32'(SLOTS_PER_GROUP - 1)) begin
          scan_s <= '0;
          scan_g <= scan_g + 1'b1;
        end else begin
          scan_s <= scan_s + 1'b1;
        end
      end
    end
    proc_g <= scan_g;
    proc_s <= scan_s;
  end

  // Pick result register; report no task when nothing is active
  always_ff @(posedge clk) begin
    if (rst) begin
      pick_hit <= 1'b0;
      pick_g   <= '0;
      pick_s   <= '0;
      pick_bg  <= 1'b0;
    end else if (cmd.latch) begin
      pick_hit <= 1'b0;
      pick_g   <= '0;
      pick_s   <= '0;
      pick_bg  <= 1'b0;
    end else if (cmd.pick) begin
      pick_hit <= sel_hit;
      pick_g   <= sel_hit ? sel_g : '0;
      pick_s   <= sel_hit ? sel_s : '0;
      pick_bg  <= sel_hit && (5'(sel_g) >= first_bg);
    end
  end

  // Task masks
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int g = 0; g < GROUP_COUNT; g++) begin
        reg_mask[g] <= '0;
        act_mask[g] <= '0;
      end
    end else begin
      if (proc_fire) begin
        act_mask[proc_g][proc_s] <= 1'b1;
      end
      if (cmd.pick && !sel_hit) begin
        for (int g = 0; g < GROUP_COUNT; g++) begin
          if (5'(g) >= first_bg && 5'(g) < scan_groups) begin
            act_mask[g] <= reg_mask[g];
          end
        end
      end
      if (cmd.apply && pick_hit) begin
        act_mask[pick_g][pick_s] <= 1'b0;
        if (period_rdata == '0 && 5'(pick_g) < first_bg) begin
          reg_mask[pick_g][pick_s] <= 1'b0;
        end
      end
      if (cmd.write_op && op_in_range) begin
        act_mask[op_g][op_s] <= 1'b0;
        reg_mask[op_g][op_s] <= (op_q == ptd_pkg::OP_REGISTER);
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
    if (cmd.emit) begin
      out_dispatched      <= pick_hit;
      out_picked_group    <= ptd_pkg::GROUP_W'(pick_g);
      out_picked_slot     <= ptd_pkg::SLOT_W'(pick_s);
      out_from_background <= pick_bg;
      out_now_tick        <= tick_count;
    end
  end

  // Status to controller
  always_comb begin
    stat.op        = op_q;
    stat.scan_none = (scan_groups == 5'd0);
    stat.scan_last = (32'(scan_s) == 32'(SLOTS_PER_GROUP - 1)) &&
                     (5'(scan_g) + 5'd1 == scan_groups);
    stat.out_free  = !out_valid || out_ready;
  end

endmodule

`default_nettype wire

// ===== verif/ptd_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ptd_checker
// Watches the request and result channels of the task dispatcher, keeps its
// own copy of the task tables and group settings, predicts each result and
// compares it field by field in arrival order.
// ----------------------------------------------------------------------------
module ptd_checker (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [ptd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [ptd_pkg::CFG_W-1:0]     cfg_data,
  ptd_req_if                            req_mon,
  ptd_rsp_if                            rsp_mon,
  output int                            failures,
  output int                            pending
);

  localparam int NGRP = 8;
  localparam int NSLOT = 32;

  typedef struct packed {
    logic        dispatched;
    logic [2:0]  picked_group;
    logic [4:0]  picked_slot;
    logic        from_background;
    logic [31:0] now_tick;
  } sched_result_t;

  logic [ptd_pkg::CFG_W-1:0] groups_cfg;
  logic [ptd_pkg::CFG_W-1:0] backgr_cfg;
  logic [31:0]      ticks;
  logic [31:0]      reg_mask [NGRP];
  logic [31:0]      act_mask [NGRP];
  logic [31:0]      start_at [NGRP*NSLOT];
  logic [31:0]      period_of [NGRP*NSLOT];

  sched_result_t    sched_q[$];

  task automatic report(input string what);
    $display("mismatch at %0t: %s", $realtime, what);
    failures++;
  endtask

  // Compute the result of one accepted request and update the task tables
  function automatic sched_result_t schedule(input ptd_pkg::op_t op, input logic [2:0] grp,
                                             input logic [4:0] slot,
                                             input logic [31:0] per,
                                             input logic [31:0] fst);
    sched_result_t r;
    int ng;
    int nb;
    int fb;
    int k;
    bit hit;
    r = '0;
    hit = 0;
    ng = (groups_cfg > NGRP) ? NGRP : int'(groups_cfg);
    nb = (backgr_cfg > ng) ? ng : int'(backgr_cfg);
    fb = ng - nb;
    case (op)
      ptd_pkg::OP_TICK: begin
        ticks = ticks + 32'd1;
        for (int g = 0; g < ng; g++) begin
          for (int s = 0; s < NSLOT; s++) begin
            k = g * NSLOT + s;
            if (reg_mask[g][s] && (ticks - start_at[k]) >= period_of[k]) begin
              act_mask[g][s] = 1'b1;
              start_at[k] = start_at[k] + period_of[k];
            end
          end
        end
      end
      ptd_pkg::OP_DISPATCH: begin
        for (int g = 0; g < ng && !hit; g++) begin
          for (int s = 0; s < NSLOT && !hit; s++) begin
            if (act_mask[g][s]) begin
              hit = 1;
              act_mask[g][s] = 1'b0;
              if (period_of[g*NSLOT+s] == 32'd0 && g < fb) reg_mask[g][s] = 1'b0;
              r.dispatched = 1'b1;
              r.picked_group = 3'(g);
              r.picked_slot = 5'(s);
              r.from_background = (g >= fb);
            end
          end
        end
        // Idle: reload background groups
        if (!hit) begin
          for (int g = fb; g < ng; g++) act_mask[g] = reg_mask[g];
        end
      end
      ptd_pkg::OP_REGISTER: begin
        k = int'(grp) * NSLOT + int'(slot);
        reg_mask[grp][slot] = 1'b1;
        act_mask[grp][slot] = 1'b0;
        period_of[k] = per;
        start_at[k] = fst;
      end
      default: begin
        reg_mask[grp][slot] = 1'b0;
        act_mask[grp][slot] = 1'b0;
      end
    endcase
    r.now_tick = ticks;
    return r;
  endfunction

  always @(posedge clk) begin
    sched_result_t got;
    sched_result_t want;
    if (rst) begin
      groups_cfg = ptd_pkg::GROUPS_IN_USE_RST;
      backgr_cfg = ptd_pkg::BACKGROUND_GROUPS_RST;
      ticks = '0;
      for (int g = 0; g < NGRP; g++) begin
        reg_mask[g] = '0;
        act_mask[g] = '0;
      end
      for (int k = 0; k < NGRP*NSLOT; k++) begin
        start_at[k] = '0;
        period_of[k] = '0;
      end
      sched_q.delete();
    end else begin
      // Compare the result that left this edge
      if (rsp_mon.valid && rsp_mon.ready) begin
        got = {rsp_mon.dispatched, rsp_mon.picked_group, rsp_mon.picked_slot,
               rsp_mon.from_background, rsp_mon.now_tick};
        if (sched_q.size() == 0) begin
          report("result with no request outstanding");
        end else begin
          want = sched_q.pop_front();
          if (got.dispatched !== want.dispatched)
            report($sformatf("dispatched %0b, want %0b", got.dispatched, want.dispatched));
          if (got.picked_group !== want.picked_group)
            report($sformatf("picked_group %0d, want %0d", got.picked_group,
                             want.picked_group));
          if (got.picked_slot !== want.picked_slot)
            report($sformatf("picked_slot %0d, want %0d", got.picked_slot,
                             want.picked_slot));
          if (got.from_background !== want.from_background)
            report($sformatf("from_background %0b, want %0b", got.from_background,
                             want.from_background));
          if (got.now_tick !== want.now_tick)
            report($sformatf("now_tick %0d, want %0d", got.now_tick, want.now_tick));
        end
      end
      // Predict for the request taken this edge
      if (req_mon.valid && req_mon.ready)
        sched_q.push_back(schedule(ptd_pkg::op_t'(req_mon.op), req_mon.group,
                                   req_mon.slot, req_mon.period, req_mon.first_start));
      if (cfg_we) begin
        if (cfg_index == ptd_pkg::CFG_GROUPS_IN_USE) groups_cfg = cfg_data;
        else if (cfg_index == ptd_pkg::CFG_BACKGROUND_GROUPS) backgr_cfg = cfg_data;
      end
    end
    pending = sched_q.size();
  end

  initial begin
    failures = 0;
    pending = 0;
  end

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Stimulus for the periodic task dispatcher: directed task setups, then
// random traffic over several group settings, with bursty requests and a
// stalling result side. The checker beside the block scores every result.
// ----------------------------------------------------------------------------
module tb_top;

  logic                          clk;
  logic                          rst;
  logic                          cfg_we;
  logic [ptd_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [ptd_pkg::CFG_W-1:0]     cfg_data;
  int                   failures;
  int                   pending;
  int                   burst_left;
  bit                   req_up;
  int                   hold_asked;
  int                   hold_done;

  ptd_req_if req_ch();
  ptd_rsp_if rsp_ch();

  periodic_task_dispatcher_top uut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .req(req_ch), .rsp(rsp_ch)
  );

  ptd_checker chk (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .req_mon(req_ch), .rsp_mon(rsp_ch),
    .failures(failures), .pending(pending)
  );

  always #2 clk = ~clk;

  // Send one request; end bursts with a random gap
  task automatic send_req(input ptd_pkg::op_t op, input logic [2:0] grp,
                          input logic [4:0] slot,
                          input logic [31:0] per, input logic [31:0] fst);
    int gap;
    req_ch.valid <= 1'b1;
    req_ch.op <= op;
    req_ch.group <= grp;
    req_ch.slot <= slot;
    req_ch.period <= per;
    req_ch.first_start <= fst;
    req_up = 1;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    burst_left--;
    if (burst_left <= 0) begin
      burst_left = $urandom_range(1, 12);
      gap = $urandom_range(0, 6);
      if (gap > 0) begin
        req_ch.valid <= 1'b0;
        req_up = 0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // Hold requests until every result is back
  task automatic drain();
    if (req_up) begin
      req_ch.valid <= 1'b0;
      req_up = 0;
    end
    @(posedge clk);
    wait (pending == 0);
    @(posedge clk);
  endtask

  task automatic set_groups(input logic [ptd_pkg::CFG_W-1:0] ngrp,
                            input logic [ptd_pkg::CFG_W-1:0] nbg);
    drain();
    repeat (8) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= ptd_pkg::CFG_GROUPS_IN_USE;
    cfg_data <= ngrp;
    @(posedge clk);
    cfg_index <= ptd_pkg::CFG_BACKGROUND_GROUPS;
    cfg_data <= nbg;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Mostly well-formed traffic: short periods, near starts, frequent dispatch
  task automatic random_req();
    int pick;
    ptd_pkg::op_t op;
    logic [31:0] per;
    logic [31:0] fst;
    pick = $urandom_range(0, 99);
    if (pick < 22) op = ptd_pkg::OP_TICK;
    else if (pick < 62) op = ptd_pkg::OP_DISPATCH;
    else if (pick < 88) op = ptd_pkg::OP_REGISTER;
    else op = ptd_pkg::OP_REMOVE;
    pick = $urandom_range(0, 9);
    per = (pick < 2) ? 32'd0 : (pick < 8) ? 32'($urandom_range(1, 6)) : $urandom;
    pick = $urandom_range(0, 9);
    fst = (pick < 7) ? 32'($urandom_range(0, 40)) : $urandom;
    send_req(op, 3'($urandom_range(0, 7)), 5'($urandom_range(0, 31)), per, fst);
  endtask

  // Result side: stall patterns, plus long hold-offs on request
  initial begin
    int mode;
    int left;
    left = 0;
    mode = 0;
    forever begin
      @(posedge clk);
      if (hold_asked != hold_done) begin
        hold_done++;
        rsp_ch.ready <= 1'b0;
        repeat (400) @(posedge clk);
      end else begin
        if (left == 0) begin
          mode = $urandom_range(0, 2);
          left = $urandom_range(10, 60);
        end
        left--;
        case (mode)
          0: rsp_ch.ready <= 1'b1;
          1: rsp_ch.ready <= ($urandom_range(0, 1) == 1);
          default: rsp_ch.ready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  initial begin
    #4ms;
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    logic [ptd_pkg::CFG_W-1:0] grp_set [8];
    logic [ptd_pkg::CFG_W-1:0] bg_set [8];
    clk = 1'b0;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    req_ch.valid = 1'b0;
    req_ch.op = ptd_pkg::OP_TICK;
    req_ch.group = '0;
    req_ch.slot = '0;
    req_ch.period = '0;
    req_ch.first_start = '0;
    rsp_ch.ready = 1'b0;
    burst_left = 4;
    req_up = 0;
    hold_asked = 0;
    hold_done = 0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: extremes, one-shot, background reload, removal
    send_req(ptd_pkg::OP_REGISTER, 3'd0, 5'd0, 32'd0, 32'd0);
    send_req(ptd_pkg::OP_REGISTER, 3'd0, 5'd31, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_req(ptd_pkg::OP_REGISTER, 3'd7, 5'd31, 32'd1, 32'd0);
    send_req(ptd_pkg::OP_REGISTER, 3'd3, 5'd5, 32'd2, 32'd0);
    send_req(ptd_pkg::OP_REGISTER, 3'd5, 5'd17, 32'd0, 32'hAAAA_5555);
    send_req(ptd_pkg::OP_TICK, 3'd7, 5'd31, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_req(ptd_pkg::OP_TICK, 3'd0, 5'd0, 32'd0, 32'd0);
    repeat (5) send_req(ptd_pkg::OP_DISPATCH, 3'd0, 5'd0, 32'd0, 32'd0);
    send_req(ptd_pkg::OP_DISPATCH, 3'd0, 5'd0, 32'd0, 32'd0);
    send_req(ptd_pkg::OP_DISPATCH, 3'd0, 5'd0, 32'd0, 32'd0);
    send_req(ptd_pkg::OP_REMOVE, 3'd7, 5'd31, 32'd0, 32'd0);
    send_req(ptd_pkg::OP_REMOVE, 3'd0, 5'd31, 32'h5555_AAAA, 32'h1234_5678);
    send_req(ptd_pkg::OP_REGISTER, 3'd2, 5'd9, 32'h8000_0000, 32'h7FFF_FFFF);
    send_req(ptd_pkg::OP_TICK, 3'd0, 5'd0, 32'd0, 32'd0);
    repeat (3) send_req(ptd_pkg::OP_DISPATCH, 3'd0, 5'd0, 32'd0, 32'd0);

    // Random phases over group settings, extremes included
    grp_set = '{4'd8, 4'd15, 4'd0, 4'd1, 4'd3, 4'd8, 4'd5, 4'd2};
    bg_set  = '{4'd1, 4'd15, 4'd3, 4'd0, 4'd2, 4'd0, 4'd8, 4'd1};
    for (int ph = 0; ph < 8; ph++) begin
      set_groups(grp_set[ph], bg_set[ph]);
      for (int n = 0; n < 88; n++) begin
        if (ph == 2 && n == 40) begin
          hold_asked++;
        end
        if (ph == 4 && n == 30) drain();
        random_req();
      end
    end

    drain();
    repeat (300) @(posedge clk);
    if (failures == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
